### sv/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

  // Operand and result word width
  localparam int WORD_W = 32;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [2:0]               status;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       latch;
    logic       push;
    logic       alu_go;
    logic       div_start;
    logic       div_commit;
    logic       set_err;
    logic [2:0] err_code;
    logic       emit;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic err_any;
    logic is_digit;
    logic is_arith;
    logic is_div;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic div_busy;
    logic div_done;
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/pfe_ram.sv
`default_nettype none

module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/pfe_div.sv
`default_nettype none

module pfe_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pfe_pkg::WORD_W-1:0] dividend,
  input  wire logic [pfe_pkg::WORD_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic      [pfe_pkg::WORD_W-1:0] quotient
);

  localparam int W     = pfe_pkg::WORD_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  // One restoring step per cycle on magnitudes, sign applied at the end
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend[W-1] ? -dividend : dividend;
      dvs_nxt  = divisor[W-1] ? -divisor : divisor;
      rem_nxt  = '0;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

`default_nettype wire

### sv/pfe_dp.sv
`default_nettype none

module pfe_dp #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfe_pkg::in_word_t  in_word,
  input  wire pfe_pkg::dp_cmd_t   cmd,
  output pfe_pkg::dp_sts_t        sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pfe_pkg::out_word_t      out_word
);

  localparam int W  = pfe_pkg::WORD_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]         char_r, char_nxt;
  logic               last_r, last_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [W-1:0]       tos_r, tos_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfe_pkg::out_word_t out_word_r, out_word_nxt;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [W-1:0]  lhs;
  logic [W-1:0]  prod;
  logic [W-1:0]  alu_res;
  logic [W-1:0]  div_q;
  logic          div_busy;
  logic          div_done;
  logic          ram_we;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  // Entries below the top of stack live in the RAM; the top lives in tos_r
  assign ram_we = cmd.push && (count_r != '0);

  pfe_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_m1[AW-1:0]),
    .wr_data (tos_r),
    .rd_addr (cnt_m2[AW-1:0]),
    .rd_data (lhs)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lhs),
    .divisor  (tos_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Add, subtract and multiply are combinational, low word kept
  assign prod = lhs * tos_r;

  always_comb begin
    case (char_r)
      pfe_pkg::CH_PLUS:  alu_res = lhs + tos_r;
      pfe_pkg::CH_MINUS: alu_res = lhs - tos_r;
      default:           alu_res = prod;
    endcase
  end

  // Decode status for the controller
  always_comb begin
    sts.err_any  = (err_r != pfe_pkg::ST_OK);
    sts.is_digit = (char_r >= pfe_pkg::CH_ZERO) && (char_r <= pfe_pkg::CH_NINE);
    sts.is_arith = (char_r == pfe_pkg::CH_PLUS) || (char_r == pfe_pkg::CH_MINUS) ||
                   (char_r == pfe_pkg::CH_STAR);
    sts.is_div   = (char_r == pfe_pkg::CH_SLASH);
    sts.full     = (count_r >= CW'(STACK_DEPTH));
    sts.lt2      = (count_r < CW'(2));
    sts.rhs_zero = (tos_r == '0);
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.last     = last_r;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Advance stack, error and output word
  always_comb begin
    char_nxt      = char_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (cmd.latch) begin
      char_nxt = in_word.char_code;
      last_nxt = in_word.last_char;
    end
    if (cmd.push) begin
      tos_nxt   = W'(char_r - pfe_pkg::CH_ZERO);
      count_nxt = count_r + CW'(1);
    end
    if (cmd.alu_go) begin
      tos_nxt   = alu_res;
      count_nxt = cnt_m1;
    end
    if (cmd.div_commit) begin
      tos_nxt   = div_q;
      count_nxt = cnt_m1;
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end

    // Drop the held word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (err_r != pfe_pkg::ST_OK) begin
        out_word_nxt.status       = err_r;
        out_word_nxt.result_value = '0;
      end else if (count_r == '0) begin
        out_word_nxt.status       = pfe_pkg::ST_UNDERFLOW;
        out_word_nxt.result_value = '0;
      end else begin
        out_word_nxt.status       = pfe_pkg::ST_OK;
        out_word_nxt.result_value = tos_r;
      end
      count_nxt = '0;
      err_nxt   = pfe_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= pfe_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r     <= char_nxt;
    last_r     <= last_nxt;
    tos_r      <= tos_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### sv/pfe_ctrl.sv
`default_nettype none

module pfe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pfe_pkg::dp_sts_t sts,
  output pfe_pkg::dp_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LHS  = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequence one character: decode, fetch left operand, compute, report
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        if (sts.err_any) begin
          state_nxt = S_FIN;
        end else if (sts.is_digit) begin
          if (sts.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = pfe_pkg::ST_OVERFLOW;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (sts.lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = pfe_pkg::ST_UNDERFLOW;
        end else if (!(sts.is_arith || sts.is_div)) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = pfe_pkg::ST_INVALID;
        end else if (sts.is_div && sts.rhs_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = pfe_pkg::ST_DIVZERO;
        end else begin
          state_nxt = S_LHS;
        end
      end
      S_LHS: begin
        if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end else begin
          cmd.alu_go = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/postfix_expression_evaluator.sv
`default_nettype none

// Channel   Ports                             Word
// input     in_valid, in_stall, in_word       char_code, last_char
// output    out_valid, out_stall, out_word    result_value, status
//
// A digit or a failed character runs through S_IDLE, S_EXEC and S_FIN; + - *
// add S_LHS, and / also waits in S_DIVW (one quotient bit per cycle in the restoring divider).
// The top of stack is a register; the entries beneath sit in a RAM with registered read.
// Reset clears the stack count, error and output valid; no clearing pass.
// A held result word waits in the output register; the next expression's
// characters are taken meanwhile, and only a second result waits for it.

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pfe_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pfe_pkg::out_word_t      out_word
);

  pfe_pkg::dp_cmd_t cmd;
  pfe_pkg::dp_sts_t sts;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfe_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Hold off new characters while one is in work
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // Never overwrite a result word still held by the receiver
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // Divider runs only inside one character's work
  a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> in_stall)
    else $error("input open while divider busy");

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;

  localparam int          DEPTH       = 128;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_CHARS  = 1250;
  // Any character that is neither a digit nor an operator
  localparam logic [7:0]  CH_LETTER_A = 8'h61;

  typedef struct packed {
    pfe_pkg::in_word_t w;
    logic              drain;
  } char_item_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  pfe_pkg::in_word_t  in_word   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  pfe_pkg::out_word_t out_word;

  // Predictor state
  logic [31:0] rpn_stack [0:DEPTH-1];
  int unsigned rpn_depth = 0;
  logic [2:0]  rpn_err   = pfe_pkg::ST_OK;

  pfe_pkg::in_word_t  expr_q[$];
  char_item_t         char_q[$];
  pfe_pkg::out_word_t rpn_results_q[$];

  int unsigned errs       = 0;
  int unsigned cycles     = 0;
  int unsigned tx_gap     = 0;
  int unsigned rx_wait    = 0;
  int unsigned rx_count   = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;

  postfix_expression_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  // Apply one character to the predicted stack; queue the result on the last one
  function automatic void rpn_apply(pfe_pkg::in_word_t w);
    logic [31:0]        lhs, rhs, res;
    longint             quo;
    pfe_pkg::out_word_t r;
    if (rpn_err == pfe_pkg::ST_OK) begin
      if (w.char_code >= pfe_pkg::CH_ZERO && w.char_code <= pfe_pkg::CH_NINE) begin
        if (rpn_depth >= DEPTH) begin
          rpn_err = pfe_pkg::ST_OVERFLOW;
        end else begin
          rpn_stack[rpn_depth] = {24'd0, w.char_code - pfe_pkg::CH_ZERO};
          rpn_depth++;
        end
      end else if (rpn_depth < 2) begin
        rpn_err = pfe_pkg::ST_UNDERFLOW;
      end else begin
        rhs = rpn_stack[rpn_depth-1];
        lhs = rpn_stack[rpn_depth-2];
        res = '0;
        case (w.char_code)
          pfe_pkg::CH_PLUS:  res = lhs + rhs;
          pfe_pkg::CH_MINUS: res = lhs - rhs;
          pfe_pkg::CH_STAR:  res = lhs * rhs;
          pfe_pkg::CH_SLASH: begin
            if (rhs == '0) begin
              rpn_err = pfe_pkg::ST_DIVZERO;
            end else begin
              // 64-bit divide so that most negative over minus one wraps cleanly
              quo = longint'($signed(lhs)) / longint'($signed(rhs));
              res = quo[31:0];
            end
          end
          default:  rpn_err = pfe_pkg::ST_INVALID;
        endcase
        if (rpn_err == pfe_pkg::ST_OK) begin
          rpn_depth--;
          rpn_stack[rpn_depth-1] = res;
        end
      end
    end
    if (w.last_char) begin
      r.status       = rpn_err;
      r.result_value = '0;
      if (rpn_err == pfe_pkg::ST_OK) begin
        if (rpn_depth == 0) r.status = pfe_pkg::ST_UNDERFLOW;
        else r.result_value = rpn_stack[rpn_depth-1];
      end
      rpn_results_q.push_back(r);
      rpn_depth = 0;
      rpn_err   = pfe_pkg::ST_OK;
    end
  endfunction

  function automatic logic [7:0] dig(int unsigned n);
    return 8'(pfe_pkg::CH_ZERO + n);
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return pfe_pkg::CH_PLUS;
      1:       return pfe_pkg::CH_MINUS;
      2, 3:    return pfe_pkg::CH_STAR;
      default: return pfe_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE) || c == pfe_pkg::CH_PLUS ||
           c == pfe_pkg::CH_MINUS || c == pfe_pkg::CH_STAR || c == pfe_pkg::CH_SLASH)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void add_char(logic [7:0] c);
    pfe_pkg::in_word_t w;
    w.char_code = c;
    w.last_char = 1'b0;
    expr_q.push_back(w);
  endfunction

  // Move the built expression to the send queue, marking its last character
  function automatic int unsigned flush_expr(bit drain);
    char_item_t s;
    int unsigned n;
    n = expr_q.size();
    foreach (expr_q[i]) begin
      s.w           = expr_q[i];
      s.w.last_char = (i == n - 1);
      s.drain       = drain && (i == 0);
      char_q.push_back(s);
    end
    expr_q.delete();
    return n;
  endfunction

  function automatic void put3(int unsigned a, int unsigned b, logic [7:0] op);
    add_char(dig(a));
    add_char(dig(b));
    add_char(op);
    void'(flush_expr(1'b0));
  endfunction

  // Well-formed expression; deep pushes every digit before reducing
  function automatic void gen_expr(int unsigned pushes, bit deep, bit keep_extra);
    int unsigned depth, done, floor_d;
    depth   = 0;
    done    = 0;
    floor_d = keep_extra ? $urandom_range(1, 3) : 1;
    while (done < pushes || depth > floor_d) begin
      if (done < pushes && (depth < 2 || deep || $urandom_range(0, 2) != 0)) begin
        add_char(dig($urandom_range(0, 9)));
        depth++;
        done++;
      end else begin
        add_char(rand_op());
        depth--;
      end
    end
  endfunction

  // Fill the send queue: directed cases, then random expressions
  function automatic void build_stimulus();
    int unsigned       sent, k, kind, idx, n;
    pfe_pkg::in_word_t w;
    put3(9, 5, pfe_pkg::CH_PLUS);
    put3(3, 9, pfe_pkg::CH_MINUS);
    put3(9, 8, pfe_pkg::CH_STAR);
    put3(7, 3, pfe_pkg::CH_SLASH);
    put3(5, 0, pfe_pkg::CH_SLASH);
    put3(1, 2, CH_LETTER_A);
    add_char(dig(9));
    void'(flush_expr(1'b0));
    add_char(dig(0));
    void'(flush_expr(1'b0));
    add_char(pfe_pkg::CH_PLUS);
    void'(flush_expr(1'b0));
    add_char(dig(1));
    add_char(dig(2));
    void'(flush_expr(1'b0));
    // negative quotient truncates toward zero
    add_char(dig(0));
    add_char(dig(7));
    add_char(pfe_pkg::CH_MINUS);
    add_char(dig(2));
    add_char(pfe_pkg::CH_SLASH);
    void'(flush_expr(1'b0));

    sent = 0;
    k    = 0;
    while (sent < RAND_CHARS) begin
      kind = $urandom_range(0, 99);
      if (k == 5 || k == 60) begin
        // fill the stack exactly, then reduce
        gen_expr(DEPTH, 1'b1, 1'b0);
      end else if (k == 20 || k == 90) begin
        // at least one push too many
        n = DEPTH + 1 + $urandom_range(0, 3);
        repeat (n) add_char(dig($urandom_range(0, 9)));
        repeat ($urandom_range(0, 3)) add_char(rand_op());
      end else if (k % 37 == 3) begin
        // build -2^31 by wrapping 2 * 8^10, then divide by minus one
        add_char(dig(2));
        repeat (10) begin
          add_char(dig(8));
          add_char(pfe_pkg::CH_STAR);
        end
        add_char(dig(0));
        add_char(dig(1));
        add_char(pfe_pkg::CH_MINUS);
        add_char(pfe_pkg::CH_SLASH);
      end else if (kind < 72) begin
        gen_expr($urandom_range(1, 12), 1'b0, $urandom_range(0, 5) == 0);
      end else if (kind < 90) begin
        // broken expression: drop a stray character somewhere in it
        gen_expr($urandom_range(1, 8), 1'b0, 1'b0);
        w.last_char = 1'b0;
        case ($urandom_range(0, 2))
          0:       w.char_code = rand_bad_char();
          1:       w.char_code = rand_op();
          default: w.char_code = 8'($urandom_range(0, 255));
        endcase
        idx = $urandom_range(0, expr_q.size());
        expr_q.insert(idx, w);
        repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 255)));
      end else begin
        // noise
        repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
      end
      sent += flush_expr(k % 45 == 10);
      k++;
    end
  endfunction

  // Send side: predict on acceptance, then idle or offer the next word
  always @(posedge clk) begin : tx
    int unsigned gap;
    if (in_valid && !in_stall) rpn_apply(in_word);
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (in_valid && in_stall) begin
      // hold the stalled word
    end else begin
      gap = tx_gap;
      if (in_valid) begin
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        tx_gap   <= gap - 1;
      end else if (char_q.size() != 0 &&
                   !(char_q[0].drain && rpn_results_q.size() != 0)) begin
        in_word  <= char_q[0].w;
        in_valid <= 1'b1;
        char_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receive side: check each result word, then stall for a drawn while
  always @(posedge clk) begin : rx
    pfe_pkg::out_word_t want;
    int unsigned        w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_count++;
        if (rpn_results_q.size() == 0) begin
          $error("unexpected result word: result_value %0d status %0d",
                 out_word.result_value, out_word.status);
          errs++;
        end else begin
          want = rpn_results_q.pop_front();
          if (out_word.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   want.result_value, out_word.result_value);
            errs++;
          end
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            errs++;
          end
        end
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        w = rx_calm ? 0 : $urandom_range(0, 13);
        // long hold-off so the block fills up and stalls its input
        if (rx_count == 25 || rx_count == 80) w = 600;
        out_stall <= (w != 0);
        rx_wait   <= (w == 0) ? 0 : w - 1;
      end else if (rx_wait != 0) begin
        out_stall <= 1'b1;
        rx_wait   <= rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("postfix_expression_evaluator test failed");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // drain: every word sent, every result back, then a settling tail
    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (rpn_results_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errs == 0) begin
      $display("postfix_expression_evaluator test passed");
    end else begin
      $display("postfix_expression_evaluator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
